@@ hw/rtl/sukt_pkg.sv @@
// Shared types and constants of the sorted unique key table.
// Used by sukt_cmp, the core and the bench; depends on nothing.
package sukt_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_W    = 32;
	localparam int ACT_W    = 3;
	localparam int STAT_W   = 3;
	localparam int RANK_W   = 7;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT   = 3'd0,
		ACT_DELETE   = 3'd1,
		ACT_LIST_ASC = 3'd2,
		ACT_LIST_DSC = 3'd3,
		ACT_SEARCH   = 3'd4
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE     = 3'd0,
		ST_DUP      = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_SEARCH    = 7'b0000010,
		S_INS_SHIFT = 7'b0000100,
		S_DEL_SHIFT = 7'b0001000,
		S_WRITE     = 7'b0010000,
		S_RESULT    = 7'b0100000,
		S_LIST      = 7'b1000000
	} state_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

endpackage

@@ hw/rtl/sukt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module sukt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hw/rtl/sukt_cmp.sv @@
// Shared signed key comparator used by the search walk.
// Depends on sukt_pkg.
module sukt_cmp import sukt_pkg::*; (
	input  logic signed [KEY_W-1:0] a,
	input  logic signed [KEY_W-1:0] b,
	output cmp_res_t                res
);

	always_comb begin
		res.lt = (a < b);
		res.eq = (a == b);
	end

endmodule

@@ hw/rtl/sorted_unique_key_table_core.sv @@
// Top level of the sorted unique key table: sequencer, key RAM, comparator, output register.
// Depends on sukt_pkg, sukt_ram and sukt_cmp.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------
//  in      | in_valid, in_ready | action[2:0], key[31:0]
//  out     | out_valid,out_ready| status[2:0], value[31:0], rank[6:0], last
//
// Steps of each action:
//   insert: search walk, shift of the larger keys up, write of the new key, result.
//   delete: search walk, shift of the following keys down, count update, result.
//   search: search walk, then result; empty table: result only.
//   listing: one key per cycle while the output side keeps taking transfers.
// These steps follow from the single read and single write port of the key RAM.
// arst_n clears the sequencer, the entry count and the output valid; RAM contents stay undefined.
// in_ready is high only while the sequencer is idle; a result waiting in the output
// register does not block the next input transfer. Output stalls hold the sequencer.
module sorted_unique_key_table_core import sukt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [ACT_W-1:0]         action,
	input  logic signed [KEY_W-1:0]  key,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [STAT_W-1:0]        status,
	output logic signed [KEY_W-1:0]  value,
	output logic [RANK_W-1:0]        rank,
	output logic                     last
);

	// sequencer state and operands
	state_t               state_q, state_d;
	action_t              op_q, op_d;
	logic [KEY_W-1:0]     key_q, key_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [CNT_W-1:0]     pos_q, pos_d;   // search walk position
	logic [CNT_W-1:0]     ptr_q, ptr_d;   // shift / listing pointer
	status_t              res_q, res_d;

	// output register
	logic                 out_valid_q;
	logic [STAT_W-1:0]    status_q;
	logic [KEY_W-1:0]     value_q;
	logic [RANK_W-1:0]    rank_q;
	logic                 last_q;

	logic                 ld;
	logic [STAT_W-1:0]    ld_status;
	logic [KEY_W-1:0]     ld_value;
	logic [RANK_W-1:0]    ld_rank;
	logic                 ld_last;

	// RAM port
	logic                 we;
	logic [ADDR_W-1:0]    waddr;
	logic [KEY_W-1:0]     wdata;
	logic [ADDR_W-1:0]    raddr;
	logic [KEY_W-1:0]     rdata;

	cmp_res_t             cmp;

	logic [CNT_W-1:0]     cnt_m1, pos_p1, ptr_p1, ptr_p2, ptr_m1, ptr_m2;
	logic                 out_free, in_range, hit, asc, at_end;

	sukt_ram #(
		.WIDTH(KEY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// one comparator serves every step of the walk
	sukt_cmp u_cmp (
		.a  (rdata),
		.b  (key_q),
		.res(cmp)
	);

	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign pos_p1   = pos_q + CNT_W'(1);
	assign ptr_p1   = ptr_q + CNT_W'(1);
	assign ptr_p2   = ptr_q + CNT_W'(2);
	assign ptr_m1   = ptr_q - CNT_W'(1);
	assign ptr_m2   = ptr_q - CNT_W'(2);
	assign out_free = !out_valid_q || out_ready;
	assign in_range = (pos_q < cnt_q);
	assign hit      = in_range && cmp.eq;
	assign asc      = (op_q == ACT_LIST_ASC);
	assign at_end   = asc ? (ptr_q == cnt_m1) : (ptr_q == '0);

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		key_d     = key_q;
		cnt_d     = cnt_q;
		pos_d     = pos_q;
		ptr_d     = ptr_q;
		res_d     = res_q;
		we        = 1'b0;
		waddr     = ptr_q[ADDR_W-1:0];
		wdata     = rdata;
		raddr     = pos_p1[ADDR_W-1:0];
		ld        = 1'b0;
		ld_status = ST_DONE;
		ld_value  = key_q;
		ld_rank   = '0;
		ld_last   = 1'b1;

		case (state_q)
			S_IDLE: begin
				// prefetch the first key a walk or listing needs
				raddr = (action == ACT_LIST_DSC) ? cnt_m1[ADDR_W-1:0] : '0;
				pos_d = '0;
				if (in_valid) begin
					op_d  = action_t'(action);
					key_d = key;
					case (action)
						ACT_INSERT: begin
							state_d = S_SEARCH;
						end
						ACT_DELETE, ACT_SEARCH: begin
							if (cnt_q == '0) begin
								res_d   = ST_EMPTY;
								state_d = S_RESULT;
							end else begin
								state_d = S_SEARCH;
							end
						end
						ACT_LIST_ASC, ACT_LIST_DSC: begin
							if (cnt_q == '0) begin
								res_d   = ST_EMPTY;
								key_d   = '0;
								state_d = S_RESULT;
							end else begin
								ptr_d   = (action == ACT_LIST_ASC) ? '0 : cnt_m1;
								state_d = S_LIST;
							end
						end
						default: begin
							// unknown action: transfer is dropped
						end
					endcase
				end
			end

			S_SEARCH: begin
				// rdata holds the key at pos_q
				if (in_range && cmp.lt) begin
					pos_d = pos_p1;
				end else begin
					case (op_q)
						ACT_INSERT: begin
							if (hit) begin
								res_d   = ST_DUP;
								state_d = S_RESULT;
							end else if (cnt_q == CNT_W'(CAPACITY)) begin
								res_d   = ST_FULL;
								state_d = S_RESULT;
							end else if (pos_q == cnt_q) begin
								state_d = S_WRITE;
							end else begin
								// fetch the top key, shift moves downward from cnt
								raddr   = cnt_m1[ADDR_W-1:0];
								ptr_d   = cnt_q;
								state_d = S_INS_SHIFT;
							end
						end
						ACT_DELETE: begin
							if (hit) begin
								ptr_d   = pos_q;
								state_d = S_DEL_SHIFT;
							end else begin
								res_d   = ST_NOTFOUND;
								state_d = S_RESULT;
							end
						end
						default: begin
							res_d   = hit ? ST_DONE : ST_NOTFOUND;
							state_d = S_RESULT;
						end
					endcase
				end
			end

			S_INS_SHIFT: begin
				// rdata holds key[ptr-1]
				we    = 1'b1;
				raddr = ptr_m2[ADDR_W-1:0];
				ptr_d = ptr_m1;
				if (ptr_m1 == pos_q) begin
					state_d = S_WRITE;
				end
			end

			S_WRITE: begin
				we      = 1'b1;
				waddr   = pos_q[ADDR_W-1:0];
				wdata   = key_q;
				cnt_d   = cnt_q + CNT_W'(1);
				res_d   = ST_DONE;
				state_d = S_RESULT;
			end

			S_DEL_SHIFT: begin
				// rdata holds key[ptr+1]
				raddr = ptr_p2[ADDR_W-1:0];
				if (ptr_p1 < cnt_q) begin
					we    = 1'b1;
					ptr_d = ptr_p1;
				end else begin
					cnt_d   = cnt_m1;
					res_d   = ST_DONE;
					state_d = S_RESULT;
				end
			end

			S_RESULT: begin
				if (out_free) begin
					ld        = 1'b1;
					ld_status = res_q;
					state_d   = S_IDLE;
				end
			end

			S_LIST: begin
				// hold the read address while stalled so rdata stays put
				raddr = ptr_q[ADDR_W-1:0];
				if (out_free) begin
					ld        = 1'b1;
					ld_status = ST_DONE;
					ld_value  = rdata;
					ld_rank   = RANK_W'(ptr_q) + RANK_W'(1);
					ld_last   = at_end;
					if (at_end) begin
						state_d = S_IDLE;
					end else begin
						ptr_d = asc ? ptr_p1 : ptr_m1;
						raddr = asc ? ptr_p1[ADDR_W-1:0] : ptr_m1[ADDR_W-1:0];
					end
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// operand and payload registers, no reset needed
	always_ff @(posedge clk) begin
		op_q  <= op_d;
		key_q <= key_d;
		pos_q <= pos_d;
		ptr_q <= ptr_d;
		res_q <= res_d;
		if (ld) begin
			status_q <= ld_status;
			value_q  <= ld_value;
			rank_q   <= ld_rank;
			last_q   <= ld_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value     = value_q;
	assign rank      = rank_q;
	assign last      = last_q;

endmodule

@@ bench/tb.sv @@
// Self-checking bench for sorted_unique_key_table_core: directed table, random traffic, full table, long output hold.
// Depends on sukt_pkg and the core RTL; the expected results come from a shadow table kept here.
module tb;
	import sukt_pkg::*;

	// Action codes that the block accepts and drops without a result.
	localparam logic [ACT_W-1:0] ACT_NOP_LO = 3'd5;
	localparam logic [ACT_W-1:0] ACT_NOP_HI = 3'd7;

	localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 40;   // idle margin after the last expected result
	localparam int LONG_HOLD    = 250;  // long output back-pressure, in cycles
	localparam int MAX_REPORTS  = 10;
	localparam int N_DIRECTED   = 23;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TRICKLE} rx_mode_t;

	// One result transfer as the output port shows it.
	typedef struct packed {
		status_t                 st;
		logic signed [KEY_W-1:0] val;
		logic [RANK_W-1:0]       rnk;
		logic                    lst;
	} table_result_t;

	// Directed row: fixed_exp marks single-result rows whose result is typed in here.
	typedef struct packed {
		logic [ACT_W-1:0]        act;
		logic signed [KEY_W-1:0] k;
		logic                    fixed_exp;
		status_t                 fix_status;
	} stim_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [ACT_W-1:0]        action = '0;
	logic signed [KEY_W-1:0] key = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [STAT_W-1:0]       status;
	logic signed [KEY_W-1:0] value;
	logic [RANK_W-1:0]       rank;
	logic                    last;

	// Shadow of the table contents; slots at and above shadow_count are stale.
	logic signed [KEY_W-1:0] shadow_keys [CAPACITY];
	int                      shadow_count = 0;
	table_result_t           awaited_results [$];

	int fail_count   = 0;
	int cycle_count  = 0;
	int hold_req     = 0;   // bumped by the sender, served by the receiver
	int holds_served = 0;
	int hold_left    = 0;
	int rx_window    = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int burst_left   = 0;

	stim_row_t directed_rows [N_DIRECTED] = '{
		// empty table: every keyed lookup and both listings report empty
		'{ACT_SEARCH,   32'sd5,   1'b1, ST_EMPTY},
		'{ACT_DELETE,   KEY_MIN,  1'b1, ST_EMPTY},
		'{ACT_LIST_ASC, 32'sd0,   1'b1, ST_EMPTY},
		'{ACT_LIST_DSC, -32'sd1,  1'b1, ST_EMPTY},
		'{ACT_NOP_LO,   32'sd3,   1'b0, ST_DONE},
		// fill with the extremes and a duplicate, then list, search and delete
		'{ACT_INSERT,   32'sd0,   1'b1, ST_DONE},
		'{ACT_INSERT,   KEY_MAX,  1'b1, ST_DONE},
		'{ACT_INSERT,   KEY_MIN,  1'b1, ST_DONE},
		'{ACT_INSERT,   KEY_MAX,  1'b1, ST_DUP},
		'{ACT_INSERT,   -32'sd1,  1'b1, ST_DONE},
		'{ACT_LIST_ASC, KEY_MAX,  1'b0, ST_DONE},
		'{ACT_LIST_DSC, 32'sd0,   1'b0, ST_DONE},
		'{ACT_SEARCH,   KEY_MIN,  1'b1, ST_DONE},
		'{ACT_SEARCH,   32'sd7,   1'b1, ST_NOTFOUND},
		'{ACT_DELETE,   32'sd7,   1'b1, ST_NOTFOUND},
		'{ACT_DELETE,   32'sd0,   1'b1, ST_DONE},
		'{ACT_NOP_HI,   KEY_MIN,  1'b0, ST_DONE},
		'{ACT_LIST_ASC, 32'sd0,   1'b0, ST_DONE},
		// drain back to empty
		'{ACT_DELETE,   KEY_MIN,  1'b1, ST_DONE},
		'{ACT_DELETE,   KEY_MAX,  1'b1, ST_DONE},
		'{ACT_SEARCH,   KEY_MAX,  1'b1, ST_NOTFOUND},
		'{ACT_DELETE,   -32'sd1,  1'b1, ST_DONE},
		'{ACT_LIST_DSC, 32'sd0,   1'b1, ST_EMPTY}
	};

	sorted_unique_key_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.key       (key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.value     (value),
		.rank      (rank),
		.last      (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Applies one accepted operation to the shadow table and queues the results it causes.
	task automatic apply_to_shadow_table(input logic [ACT_W-1:0] act,
			input logic signed [KEY_W-1:0] k);
		int pos;
		bit hit;
		int idx;
		pos = 0;
		while (pos < shadow_count && shadow_keys[pos] < k)
			pos++;
		hit = (pos < shadow_count) && (shadow_keys[pos] == k);
		case (act)
			ACT_INSERT: begin
				// duplicate wins over full
				if (hit) begin
					awaited_results.push_back('{ST_DUP, k, '0, 1'b1});
				end else if (shadow_count >= CAPACITY) begin
					awaited_results.push_back('{ST_FULL, k, '0, 1'b1});
				end else begin
					for (int i = shadow_count; i > pos; i--)
						shadow_keys[i] = shadow_keys[i-1];
					shadow_keys[pos] = k;
					shadow_count++;
					awaited_results.push_back('{ST_DONE, k, '0, 1'b1});
				end
			end
			ACT_DELETE, ACT_SEARCH: begin
				if (shadow_count == 0) begin
					awaited_results.push_back('{ST_EMPTY, k, '0, 1'b1});
				end else if (!hit) begin
					awaited_results.push_back('{ST_NOTFOUND, k, '0, 1'b1});
				end else begin
					if (act == ACT_DELETE) begin
						for (int i = pos; i + 1 < shadow_count; i++)
							shadow_keys[i] = shadow_keys[i+1];
						shadow_count--;
					end
					awaited_results.push_back('{ST_DONE, k, '0, 1'b1});
				end
			end
			ACT_LIST_ASC, ACT_LIST_DSC: begin
				if (shadow_count == 0) begin
					awaited_results.push_back('{ST_EMPTY, '0, '0, 1'b1});
				end else begin
					for (int i = 0; i < shadow_count; i++) begin
						idx = (act == ACT_LIST_ASC) ? i : shadow_count - 1 - i;
						awaited_results.push_back('{ST_DONE, shadow_keys[idx],
							RANK_W'(idx + 1), (i + 1 == shadow_count)});
					end
				end
			end
			default: ;   // unused codes: dropped, nothing changes
		endcase
	endtask

	// Holds one item on the input until its transfer, then predicts it.
	// added returns how many results the item queued.
	task automatic offer(input logic [ACT_W-1:0] act, input logic signed [KEY_W-1:0] k,
			output int added);
		int depth;
		in_valid <= 1'b1;
		action   <= act;
		key      <= k;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		depth = awaited_results.size();
		apply_to_shadow_table(act, k);
		added = awaited_results.size() - depth;
	endtask

	// Sender pacing: bursts of random length, random gaps between them.
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 10);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Sender pause until every queued result has arrived, plus a latency margin.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random item: keys lean on stored keys and a small range so hits are common.
	task automatic draw_random_item(output logic [ACT_W-1:0] act,
			output logic signed [KEY_W-1:0] k);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 35 && shadow_count > 0)
			k = shadow_keys[$urandom_range(0, shadow_count - 1)];
		else if (pick < 65)
			k = int'($urandom_range(0, 12)) - 6;
		else if (pick < 75)
			case ($urandom_range(0, 3))
				0: k = KEY_MIN;
				1: k = KEY_MAX;
				2: k = '0;
				default: k = '1;
			endcase
		else
			k = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 38)      act = ACT_INSERT;
		else if (pick < 56) act = ACT_DELETE;
		else if (pick < 74) act = ACT_SEARCH;
		else if (pick < 82) act = ACT_LIST_ASC;
		else if (pick < 90) act = ACT_LIST_DSC;
		else                act = ACT_W'($urandom_range(ACT_NOP_LO, ACT_NOP_HI));
	endtask

	// Random run of n counted items; dropped codes are sent but not counted.
	task automatic random_run(input int n);
		logic [ACT_W-1:0]        act;
		logic signed [KEY_W-1:0] k;
		int                      added;
		int                      made;
		made = 0;
		while (made < n) begin
			draw_random_item(act, k);
			offer(act, k, added);
			if (act < ACT_NOP_LO)
				made++;
			pace();
		end
	endtask

	// Receiver: stalls on its own pattern, switching mode when its random window runs out;
	// on request from the sender it takes a long hold, counted down in hold_left.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (holds_served != hold_req) begin
			holds_served++;
			hold_left = LONG_HOLD - 1;
			out_ready <= 1'b0;
		end else begin
			if (rx_window == 0) begin
				rx_window = $urandom_range(20, 80);
				rx_mode   = rx_mode_t'($urandom_range(0, 3));
			end
			rx_window--;
			case (rx_mode)
				RX_OPEN:   out_ready <= 1'b1;
				RX_COIN:   out_ready <= $urandom_range(0, 1);
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default:   out_ready <= (rx_window % 3 == 0);
			endcase
		end
	end

	// Output checker: every result transfer is matched against the oldest expectation.
	always @(posedge clk) begin : check_results
		table_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				if (fail_count < MAX_REPORTS)
					$display("unexpected result: status %0d value %0d rank %0d last %0b",
						status, value, rank, last);
				fail_count++;
			end else begin
				exp_r = awaited_results.pop_front();
				if (status !== exp_r.st || value !== exp_r.val ||
						rank !== exp_r.rnk || last !== exp_r.lst) begin
					if (fail_count < MAX_REPORTS)
						$display({"mismatch: exp status %0d value %0d rank %0d last %0b,",
							" got status %0d value %0d rank %0d last %0b"},
							exp_r.st, exp_r.val, exp_r.rnk, exp_r.lst,
							status, value, rank, last);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sorted_unique_key_table_core verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		stim_row_t               row;
		int                      added;
		// reset held low, then released on a rising edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Typed rows replace the prediction with the result read off
		// the row: status as given, the key back (0 for listings), rank 0, last set.
		for (int r = 0; r < N_DIRECTED; r++) begin
			row = directed_rows[r];
			offer(row.act, row.k, added);
			if (row.fixed_exp) begin
				repeat (added) void'(awaited_results.pop_back());
				awaited_results.push_back('{row.fix_status,
					(row.act == ACT_LIST_ASC || row.act == ACT_LIST_DSC) ? '0 : row.k,
					'0, 1'b1});
			end
			pace();
		end

		random_run(40);

		// Fill to capacity with full-range keys, then hit the full and
		// duplicate-over-full cases, list a full table both ways, then search and delete.
		while (shadow_count < CAPACITY) begin
			offer(ACT_INSERT, $urandom, added);
			pace();
		end
		offer(ACT_INSERT, $urandom, added);
		pace();
		offer(ACT_INSERT, shadow_keys[$urandom_range(0, CAPACITY - 1)], added);
		pace();
		offer(ACT_LIST_ASC, $urandom, added);
		pace();
		offer(ACT_LIST_DSC, $urandom, added);
		pace();
		offer(ACT_SEARCH, shadow_keys[CAPACITY - 1], added);
		pace();
		offer(ACT_DELETE, shadow_keys[0], added);

		// Long output hold while items keep coming back to back: the core
		// fills its output side and stalls the input transfer.
		hold_req <= hold_req + 1;
		repeat (8) begin
			offer((($urandom_range(0, 1) == 0) ? ACT_LIST_ASC : ACT_SEARCH),
				$urandom, added);
		end
		wait_drained();

		random_run(40);

		wait_drained();
		if (fail_count == 0)
			$display("sorted_unique_key_table_core verification clean");
		else
			$display("sorted_unique_key_table_core verification failed");
		$finish;
	end

endmodule
